@@ design/mie_pkg.sv @@
// shared constants and types for the modular inverse core
package mie_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);
    localparam logic [OPERAND_WIDTH-1:0] RESET_MODULUS = OPERAND_WIDTH'(1000000007);

    typedef logic [OPERAND_WIDTH-1:0] oper_t;

    typedef struct packed {
        logic  start;
        oper_t dividend;
        oper_t divisor;
        oper_t coef;
    } mie_div_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        oper_t rem;
        oper_t prod;
    } mie_div_rsp_t;

endpackage

@@ design/mie_divstep.sv @@
// shared serial divider: one restoring step per cycle, also accumulates quotient times coef
module mie_divstep import mie_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  mie_div_req_t req,
    output mie_div_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    oper_t            rem_reg, rem_next;
    oper_t            dvd_reg, dvd_next;
    oper_t            dsr_reg, dsr_next;
    oper_t            coef_reg, coef_next;
    oper_t            acc_reg, acc_next;

    logic [OPERAND_WIDTH:0] shifted;
    logic [OPERAND_WIDTH:0] diff;
    logic                   ge;

    assign shifted = {rem_reg, dvd_reg[OPERAND_WIDTH-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        coef_next = coef_reg;
        acc_next  = acc_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(OPERAND_WIDTH);
            rem_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            coef_next = req.coef;
            acc_next  = '0;
        end else if (busy_reg) begin
            // quotient bits shift into the dividend register from the bottom
            rem_next = ge ? diff[OPERAND_WIDTH-1:0] : shifted[OPERAND_WIDTH-1:0];
            dvd_next = {dvd_reg[OPERAND_WIDTH-2:0], ge};
            acc_next = {acc_reg[OPERAND_WIDTH-2:0], 1'b0} + (ge ? coef_reg : '0);
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        coef_reg <= coef_next;
        acc_reg  <= acc_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;
    assign rsp.prod = acc_reg;

endmodule

@@ design/modular_inverse_ext_euclid_core.sv @@
// modular inverse core: extended euclid sequencer around a shared serial divider
//
//   channel   signals                           direction
//   s_        s_valid s_ready s_value           item in
//   m_        m_valid m_ready m_inverse         result out
//             m_no_inverse
//   cfg_      cfg_wr_en cfg_wr_data             modulus write
//
// every euclid step is one pass of the serial divider (ST_ITER) plus one sequencer state (ST_LOOP);
// the result of an item follows its reduction pass (ST_RED) and all of its euclid steps
// modulus 0 or 1 skips the divider and goes from the accept straight to ST_DONE
// synchronous active-low reset sets the modulus to 1000000007 and empties the core
// s_ready is high only while idle; a finished result waits in the output register
module modular_inverse_ext_euclid_core import mie_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  oper_t s_value,
    output logic  m_valid,
    input  logic  m_ready,
    output oper_t m_inverse,
    output logic  m_no_inverse,
    input  logic  cfg_wr_en,
    input  oper_t cfg_wr_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_LOOP = 3'd2;
    localparam logic [2:0] ST_ITER = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    oper_t      modulus_reg, modulus_next;
    oper_t      m_cur_reg, m_cur_next;
    oper_t      r_prev_reg, r_prev_next;
    oper_t      r_reg, r_next;
    oper_t      s_prev_reg, s_prev_next;
    oper_t      s_reg, s_next;
    logic       neg_reg, neg_next;
    oper_t      res_inv_reg, res_inv_next;
    logic       res_none_reg, res_none_next;
    logic       m_valid_reg, m_valid_next;
    oper_t      m_inverse_reg, m_inverse_next;
    logic       m_no_inverse_reg, m_no_inverse_next;

    mie_div_req_t div_req;
    mie_div_rsp_t div_rsp;
    logic         in_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;

    mie_divstep u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_prev_reg;
        div_req.divisor  = r_reg;
        div_req.coef     = s_reg;
        if (state_reg == ST_IDLE) begin
            // value mod modulus, coefficient unused
            div_req.start    = in_fire && (modulus_reg > oper_t'(1));
            div_req.dividend = s_value;
            div_req.divisor  = modulus_reg;
            div_req.coef     = '0;
        end else if (state_reg == ST_LOOP) begin
            div_req.start = r_reg > oper_t'(1);
        end
    end

    always_comb begin
        state_next        = state_reg;
        modulus_next      = cfg_wr_en ? cfg_wr_data : modulus_reg;
        m_cur_next        = m_cur_reg;
        r_prev_next       = r_prev_reg;
        r_next            = r_reg;
        s_prev_next       = s_prev_reg;
        s_next            = s_reg;
        neg_next          = neg_reg;
        res_inv_next      = res_inv_reg;
        res_none_next     = res_none_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_inverse_next    = m_inverse_reg;
        m_no_inverse_next = m_no_inverse_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    m_cur_next = modulus_reg;
                    if (modulus_reg > oper_t'(1)) begin
                        state_next = ST_RED;
                    end else begin
                        res_inv_next  = '0;
                        res_none_next = (modulus_reg == '0);
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_RED: begin
                if (div_rsp.done) begin
                    r_prev_next = m_cur_reg;
                    r_next      = div_rsp.rem;
                    s_prev_next = '0;
                    s_next      = oper_t'(1);
                    neg_next    = 1'b0;
                    state_next  = ST_LOOP;
                end
            end
            ST_LOOP: begin
                if (r_reg > oper_t'(1)) begin
                    state_next = ST_ITER;
                end else begin
                    // final coefficient magnitude is below the modulus
                    if (r_reg == oper_t'(1)) begin
                        res_inv_next  = neg_reg ? (m_cur_reg - s_reg) : s_reg;
                        res_none_next = 1'b0;
                    end else begin
                        res_inv_next  = '0;
                        res_none_next = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_ITER: begin
                if (div_rsp.done) begin
                    r_prev_next = r_reg;
                    r_next      = div_rsp.rem;
                    s_prev_next = s_reg;
                    s_next      = s_prev_reg + div_rsp.prod;
                    neg_next    = !neg_reg;
                    state_next  = ST_LOOP;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_inverse_next    = res_inv_reg;
                    m_no_inverse_next = res_none_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            modulus_reg <= RESET_MODULUS;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            modulus_reg <= modulus_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_cur_reg        <= m_cur_next;
        r_prev_reg       <= r_prev_next;
        r_reg            <= r_next;
        s_prev_reg       <= s_prev_next;
        s_reg            <= s_next;
        neg_reg          <= neg_next;
        res_inv_reg      <= res_inv_next;
        res_none_reg     <= res_none_next;
        m_inverse_reg    <= m_inverse_next;
        m_no_inverse_reg <= m_no_inverse_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_inverse    = m_inverse_reg;
    assign m_no_inverse = m_no_inverse_reg;

    a_idle_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_rsp.busy)
        else $error("divider busy while core idle");

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_RED || state_reg == ST_ITER))
        else $error("divider result with no waiting step");

    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_inverse) |-> (m_inverse == '0))
        else $error("nonzero inverse flagged as missing");

endmodule
